[src/hiwp_pkg.sv]
// hiwp_pkg: shared types, codes and constants of the host interface word port
// no dependencies; used by every module of the block except hiwp_ram

package hiwp_pkg;

  localparam int WORD_W = 24;
  localparam int RX_FIFO_DEPTH = 16;

  localparam logic [7:0] RX_TIMEOUT_RESET = 8'd50;
  localparam logic [7:0] INT_VECTOR_RESET = 8'h0f;

  // item functions
  localparam logic [1:0] FUNC_READ = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_RX_WORD = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  // bus register indexes
  localparam logic [2:0] REG_ICR = 3'd0;
  localparam logic [2:0] REG_CVR = 3'd1;
  localparam logic [2:0] REG_ISR = 3'd2;
  localparam logic [2:0] REG_IVR = 3'd3;
  localparam logic [2:0] REG_SPARE = 3'd4;
  localparam logic [2:0] REG_TXH = 3'd5;
  localparam logic [2:0] REG_TXM = 3'd6;
  localparam logic [2:0] REG_TXL = 3'd7;

  // byte slots of a data word
  localparam logic [1:0] SLOT_H = 2'd0;
  localparam logic [1:0] SLOT_M = 2'd1;
  localparam logic [1:0] SLOT_L = 2'd2;

  localparam int ICR_HLEND_BIT = 5;
  localparam int CVR_HC_BIT = 7;
  localparam int ISR_RXDF_BIT = 0;

  typedef struct packed {
    logic [1:0]        func;
    logic [2:0]        reg_index;
    logic              halfword;
    logic [15:0]       write_data;
    logic [WORD_W-1:0] rx_word;
    logic [15:0]       tick_cycles;
  } item_t;

  typedef struct packed {
    logic [15:0]       read_data;
    logic              tx_valid;
    logic [WORD_W-1:0] tx_word;
    logic              irq_valid;
    logic [7:0]        irq_vector;
    logic              rx_can_accept;
    logic              rx_overflow;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

[src/hiwp_ram.sv]
// hiwp_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module hiwp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/hiwp_rx_fifo.sv]
// hiwp_rx_fifo: receive word queue, RAM backed, with the head word held in a register
// depends on hiwp_pkg and hiwp_ram

module hiwp_rx_fifo #(
  parameter int DEPTH = hiwp_pkg::RX_FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hiwp_pkg::fifo_ctrl_t        ctrl,
  input  logic [hiwp_pkg::WORD_W-1:0] push_word,
  output hiwp_pkg::fifo_stat_t        stat,
  output logic [hiwp_pkg::WORD_W-1:0] front_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [AW-1:0] head, head_next, tail, rd_addr;
  logic [CW-1:0] count, count_next;
  logic [hiwp_pkg::WORD_W-1:0] front, front_next, ram_rdata, second, byp_data;
  logic byp_hit;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == LAST) ? '0 : a + 1'b1;
  endfunction

  // ram output holds the entry after the head; a write at the same edge bypasses it
  assign second = byp_hit ? byp_data : ram_rdata;
  assign head_next = ctrl.pop ? wrap_inc(head) : head;
  assign rd_addr = wrap_inc(head_next);

  always_comb begin
    case ({ctrl.push, ctrl.pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_comb begin
    front_next = front;
    if (ctrl.pop) begin
      if (count > CW'(1)) begin
        front_next = second;
      end else if (ctrl.push) begin
        front_next = push_word;
      end
    end else if (ctrl.push && count == '0) begin
      front_next = push_word;
    end
  end

  hiwp_ram #(
    .WIDTH (hiwp_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.push),
    .wr_addr (tail),
    .wr_data (push_word),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      byp_hit <= 1'b0;
    end else begin
      head    <= head_next;
      count   <= count_next;
      byp_hit <= ctrl.push && (tail == rd_addr);
      if (ctrl.push) begin
        tail <= wrap_inc(tail);
      end
    end
  end

  always_ff @(posedge clk) begin
    front    <= front_next;
    byp_data <= push_word;
  end

  assign stat.empty = (count == '0);
  assign stat.full = (count == FULL_COUNT);
  assign front_word = front;

endmodule

[src/hiwp_core.sv]
// hiwp_core: bus register file, transmit assembly, receive flag and timeout logic
// depends on hiwp_pkg; drives the receive fifo through fifo_ctrl_t

module hiwp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  hiwp_pkg::item_t             item,
  input  logic [7:0]                  rx_timeout,
  input  hiwp_pkg::fifo_stat_t        fifo_stat,
  input  logic [hiwp_pkg::WORD_W-1:0] front_word,
  output hiwp_pkg::fifo_ctrl_t        fifo_ctrl,
  output hiwp_pkg::result_t           result
);

  localparam int RXDF = hiwp_pkg::ISR_RXDF_BIT;

  typedef struct packed {
    logic [7:0]                  data;
    logic [7:0]                  status;
    logic [hiwp_pkg::WORD_W-1:0] cur;
    logic                        loaded;
  } rx_rd_t;

  typedef struct packed {
    logic [2:0][7:0]             bytes;
    logic [2:0]                  mask;
    logic                        valid;
    logic [hiwp_pkg::WORD_W-1:0] word;
  } tx_put_t;

  logic [7:0] control, control_next;
  logic [7:0] vector, vector_next;
  logic [7:0] status, status_next;
  logic [7:0] int_vector, int_vector_next;
  logic [7:0] spare, spare_next;
  logic [hiwp_pkg::WORD_W-1:0] rx_current, rx_current_next;
  logic [2:0][7:0] tx_bytes, tx_bytes_next;
  logic [2:0] tx_mask, tx_mask_next;
  logic [15:0] timeout_count, timeout_count_next;

  logic le, avail, push, pop;
  logic [1:0] slot;
  logic [16:0] tick_sum;
  logic [15:0] tick_sat;
  rx_rd_t rd_a, rd_b;
  tx_put_t put_a, put_b;
  hiwp_pkg::result_t res;

  // byte read of the receive register; loads the next word when the flag is clear
  function automatic rx_rd_t get_rx(input logic [1:0] idx, input logic end_le,
                                    input logic [7:0] st,
                                    input logic [hiwp_pkg::WORD_W-1:0] cur,
                                    input logic have, input logic [hiwp_pkg::WORD_W-1:0] nxt);
    rx_rd_t r;
    r.data = '0;
    r.status = st;
    r.cur = cur;
    r.loaded = 1'b0;
    if (!st[RXDF] && have) begin
      r.cur = nxt;
      r.status[RXDF] = 1'b1;
      r.loaded = 1'b1;
    end
    if (r.status[RXDF]) begin
      case (idx)
        hiwp_pkg::SLOT_H: r.data = end_le ? r.cur[7:0] : r.cur[23:16];
        hiwp_pkg::SLOT_M: r.data = r.cur[15:8];
        default:          r.data = end_le ? r.cur[23:16] : r.cur[7:0];
      endcase
      // last byte in the current order frees the receive register
      if ((end_le && idx == hiwp_pkg::SLOT_H) || (!end_le && idx == hiwp_pkg::SLOT_L)) begin
        r.status[RXDF] = 1'b0;
      end
    end
    return r;
  endfunction

  // store one transmit byte; emits the word once all three are in
  function automatic tx_put_t put_tx(input logic [1:0] idx, input logic [7:0] val,
                                     input logic [2:0][7:0] bytes, input logic [2:0] mask,
                                     input logic end_le);
    tx_put_t p;
    p.bytes = bytes;
    p.bytes[idx] = val;
    p.mask = mask | (3'b001 << idx);
    p.valid = 1'b0;
    p.word = '0;
    if (p.mask == 3'b111) begin
      p.word = end_le ? {p.bytes[2], p.bytes[1], p.bytes[0]}
                      : {p.bytes[0], p.bytes[1], p.bytes[2]};
      p.valid = 1'b1;
      p.bytes = '0;
      p.mask = '0;
    end
    return p;
  endfunction

  assign le = control[hiwp_pkg::ICR_HLEND_BIT];
  assign avail = !fifo_stat.empty;
  assign slot = 2'(item.reg_index - hiwp_pkg::REG_TXH);
  assign tick_sum = {1'b0, timeout_count} + {1'b0, item.tick_cycles};
  assign tick_sat = tick_sum[16] ? 16'hffff : tick_sum[15:0];

  always_comb begin
    control_next = control;
    vector_next = vector;
    status_next = status;
    int_vector_next = int_vector;
    spare_next = spare;
    rx_current_next = rx_current;
    tx_bytes_next = tx_bytes;
    tx_mask_next = tx_mask;
    timeout_count_next = timeout_count;
    push = 1'b0;
    pop = 1'b0;
    res = '0;

    rd_a = get_rx(hiwp_pkg::SLOT_H, le, status, rx_current, avail, front_word);
    rd_b = rd_a;
    put_a = put_tx(hiwp_pkg::SLOT_H, item.write_data[7:0], tx_bytes, tx_mask, le);
    put_b = put_a;

    case (item.func)
      hiwp_pkg::FUNC_READ: begin
        if (!item.halfword) begin
          case (item.reg_index)
            hiwp_pkg::REG_ICR:   res.read_data = {8'h00, control};
            hiwp_pkg::REG_CVR:   res.read_data = {8'h00, vector};
            hiwp_pkg::REG_ISR:   res.read_data = {8'h00, status};
            hiwp_pkg::REG_IVR:   res.read_data = {8'h00, int_vector};
            hiwp_pkg::REG_SPARE: res.read_data = {8'h00, spare};
            default: begin
              rd_a = get_rx(slot, le, status, rx_current, avail, front_word);
              res.read_data = {8'h00, rd_a.data};
              status_next = rd_a.status;
              rx_current_next = rd_a.cur;
              pop = rd_a.loaded;
            end
          endcase
        end else if (item.reg_index == hiwp_pkg::REG_SPARE) begin
          rd_a = get_rx(hiwp_pkg::SLOT_H, le, status, rx_current, avail, front_word);
          res.read_data = {8'h00, rd_a.data};
          status_next = rd_a.status;
          rx_current_next = rd_a.cur;
          pop = rd_a.loaded;
        end else if (item.reg_index == hiwp_pkg::REG_TXM) begin
          rd_a = get_rx(hiwp_pkg::SLOT_M, le, status, rx_current, avail, front_word);
          rd_b = get_rx(hiwp_pkg::SLOT_L, le, rd_a.status, rd_a.cur,
                        avail && !rd_a.loaded, front_word);
          res.read_data = {rd_a.data, rd_b.data};
          status_next = rd_b.status;
          rx_current_next = rd_b.cur;
          pop = rd_a.loaded || rd_b.loaded;
        end
        if (pop) begin
          timeout_count_next = '0;
        end
      end

      hiwp_pkg::FUNC_WRITE: begin
        if (!item.halfword) begin
          case (item.reg_index)
            hiwp_pkg::REG_ICR: control_next = item.write_data[7:0];
            hiwp_pkg::REG_CVR: begin
              vector_next = item.write_data[7:0];
              if (item.write_data[hiwp_pkg::CVR_HC_BIT]) begin
                res.irq_valid = 1'b1;
                res.irq_vector = {item.write_data[6:0], 1'b0};
                vector_next[hiwp_pkg::CVR_HC_BIT] = 1'b0;
              end
            end
            hiwp_pkg::REG_ISR:   status_next = item.write_data[7:0];
            hiwp_pkg::REG_IVR:   int_vector_next = item.write_data[7:0];
            hiwp_pkg::REG_SPARE: spare_next = item.write_data[7:0];
            default: begin
              put_a = put_tx(slot, item.write_data[7:0], tx_bytes, tx_mask, le);
              tx_bytes_next = put_a.bytes;
              tx_mask_next = put_a.mask;
              res.tx_valid = put_a.valid;
              res.tx_word = put_a.word;
            end
          endcase
        end else if (item.reg_index == hiwp_pkg::REG_SPARE) begin
          spare_next = item.write_data[15:8];
          put_a = put_tx(hiwp_pkg::SLOT_H, item.write_data[7:0], tx_bytes, tx_mask, le);
          tx_bytes_next = put_a.bytes;
          tx_mask_next = put_a.mask;
          res.tx_valid = put_a.valid;
          res.tx_word = put_a.word;
        end else if (item.reg_index == hiwp_pkg::REG_TXM) begin
          put_a = put_tx(hiwp_pkg::SLOT_M, item.write_data[15:8], tx_bytes, tx_mask, le);
          put_b = put_tx(hiwp_pkg::SLOT_L, item.write_data[7:0], put_a.bytes, put_a.mask, le);
          tx_bytes_next = put_b.bytes;
          tx_mask_next = put_b.mask;
          res.tx_valid = put_a.valid || put_b.valid;
          res.tx_word = put_a.valid ? put_a.word : put_b.word;
        end
      end

      hiwp_pkg::FUNC_RX_WORD: begin
        push = !fifo_stat.full;
        res.rx_overflow = fifo_stat.full;
        // with an empty queue the word just delivered is the one loaded
        if (!status[RXDF] && (avail || push)) begin
          pop = 1'b1;
          rx_current_next = avail ? front_word : item.rx_word;
          status_next[RXDF] = 1'b1;
          timeout_count_next = '0;
        end
      end

      default: begin
        if (status[RXDF] && avail) begin
          if (tick_sat >= {8'h00, rx_timeout}) begin
            pop = 1'b1;
            rx_current_next = front_word;
            timeout_count_next = '0;
          end else begin
            timeout_count_next = tick_sat;
          end
        end
      end
    endcase

    res.rx_can_accept = !status_next[RXDF];
  end

  assign fifo_ctrl.push = fire && push;
  assign fifo_ctrl.pop = fire && pop;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      control       <= '0;
      vector        <= '0;
      status        <= '0;
      int_vector    <= hiwp_pkg::INT_VECTOR_RESET;
      spare         <= '0;
      rx_current    <= '0;
      tx_bytes      <= '0;
      tx_mask       <= '0;
      timeout_count <= '0;
    end else if (fire) begin
      control       <= control_next;
      vector        <= vector_next;
      status        <= status_next;
      int_vector    <= int_vector_next;
      spare         <= spare_next;
      rx_current    <= rx_current_next;
      tx_bytes      <= tx_bytes_next;
      tx_mask       <= tx_mask_next;
      timeout_count <= timeout_count_next;
    end
  end

endmodule

[src/host_interface_word_port_unit.sv]
// host_interface_word_port_unit: top level of the host word port
// depends on hiwp_pkg, hiwp_core and hiwp_rx_fifo
// path: the input transfer loads the input register, and the result register loads from it
// when the result register is free or being drained (out_ready)
// throughput one item per cycle while out_ready does not stall the result register
// reset: synchronous; registers, flags and timeout return to reset values, fifo empty

module host_interface_word_port_unit #(
  parameter int RX_FIFO_DEPTH = hiwp_pkg::RX_FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [2:0]                  reg_index,
  input  logic                        halfword,
  input  logic [15:0]                 write_data,
  input  logic [hiwp_pkg::WORD_W-1:0] rx_word,
  input  logic [15:0]                 tick_cycles,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 read_data,
  output logic                        tx_valid,
  output logic [hiwp_pkg::WORD_W-1:0] tx_word,
  output logic                        irq_valid,
  output logic [7:0]                  irq_vector,
  output logic                        rx_can_accept,
  output logic                        rx_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data
);

  logic item_valid, fire;
  hiwp_pkg::item_t item;
  hiwp_pkg::result_t res, res_q;
  hiwp_pkg::fifo_ctrl_t fifo_ctrl;
  hiwp_pkg::fifo_stat_t fifo_stat;
  logic [hiwp_pkg::WORD_W-1:0] front_word;
  logic [7:0] rx_timeout;

  // the held item moves on whenever the result register is free or being drained
  assign fire = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      rx_timeout <= hiwp_pkg::RX_TIMEOUT_RESET;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        rx_timeout <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.func        <= func;
      item.reg_index   <= reg_index;
      item.halfword    <= halfword;
      item.write_data  <= write_data;
      item.rx_word     <= rx_word;
      item.tick_cycles <= tick_cycles;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  hiwp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (item),
    .rx_timeout (rx_timeout),
    .fifo_stat  (fifo_stat),
    .front_word (front_word),
    .fifo_ctrl  (fifo_ctrl),
    .result     (res)
  );

  hiwp_rx_fifo #(
    .DEPTH (RX_FIFO_DEPTH)
  ) u_rx_fifo (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (fifo_ctrl),
    .push_word  (item.rx_word),
    .stat       (fifo_stat),
    .front_word (front_word)
  );

  assign read_data = res_q.read_data;
  assign tx_valid = res_q.tx_valid;
  assign tx_word = res_q.tx_word;
  assign irq_valid = res_q.irq_valid;
  assign irq_vector = res_q.irq_vector;
  assign rx_can_accept = res_q.rx_can_accept;
  assign rx_overflow = res_q.rx_overflow;

endmodule

[verif/tb_host_interface_word_port_unit.sv]
// tb_host_interface_word_port_unit: self-checking testbench of the host word port
// depends on hiwp_pkg and host_interface_word_port_unit; predicts every result
// from its own model of the bus registers, receive queue and transmit assembly

module tb_host_interface_word_port_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  func = '0;
  logic [2:0]                  reg_index = '0;
  logic                        halfword = 1'b0;
  logic [15:0]                 write_data = '0;
  logic [hiwp_pkg::WORD_W-1:0] rx_word = '0;
  logic [15:0]                 tick_cycles = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [15:0]                 read_data;
  logic                        tx_valid;
  logic [hiwp_pkg::WORD_W-1:0] tx_word;
  logic                        irq_valid;
  logic [7:0]                  irq_vector;
  logic                        rx_can_accept;
  logic                        rx_overflow;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [7:0]                  cfg_data = '0;

  host_interface_word_port_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .reg_index     (reg_index),
    .halfword      (halfword),
    .write_data    (write_data),
    .rx_word       (rx_word),
    .tick_cycles   (tick_cycles),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .tx_valid      (tx_valid),
    .tx_word       (tx_word),
    .irq_valid     (irq_valid),
    .irq_vector    (irq_vector),
    .rx_can_accept (rx_can_accept),
    .rx_overflow   (rx_overflow),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted port state
  logic [7:0]                  rx_tmo_limit;
  logic [7:0]                  ctrl_b, cvr_b, isr_b, ivr_b, spare_b;
  logic [hiwp_pkg::WORD_W-1:0] rx_cur;
  logic [hiwp_pkg::WORD_W-1:0] rx_fifo [hiwp_pkg::RX_FIFO_DEPTH];
  int                          fifo_cnt, fifo_head;
  logic [7:0]                  tx_b [3];
  logic [2:0]                  tx_mask;
  int                          tmo_cnt;
  hiwp_pkg::result_t           step_out;

  hiwp_pkg::item_t   bus_items[$];
  hiwp_pkg::result_t host_port_results[$];

  int offered = 0;
  int accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int tx_words = 0;
  int vectors = 0;
  int dropped = 0;
  int limits_used = 0;

  int burst_left = 8;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int rcv_cycle = 0;

  function automatic void host_port_reset();
    rx_tmo_limit = hiwp_pkg::RX_TIMEOUT_RESET;
    ctrl_b = '0;
    cvr_b = '0;
    isr_b = '0;
    ivr_b = hiwp_pkg::INT_VECTOR_RESET;
    spare_b = '0;
    rx_cur = '0;
    foreach (rx_fifo[k]) rx_fifo[k] = '0;
    fifo_cnt = 0;
    fifo_head = 0;
    foreach (tx_b[k]) tx_b[k] = '0;
    tx_mask = '0;
    tmo_cnt = 0;
  endfunction

  function automatic void rx_load();
    if (fifo_cnt == 0) return;
    tmo_cnt = 0;
    rx_cur = rx_fifo[fifo_head];
    fifo_head = (fifo_head + 1) % hiwp_pkg::RX_FIFO_DEPTH;
    fifo_cnt--;
    isr_b[hiwp_pkg::ISR_RXDF_BIT] = 1'b1;
  endfunction

  function automatic logic [7:0] rx_byte(logic [1:0] slot);
    logic       little;
    logic [7:0] b;
    little = ctrl_b[hiwp_pkg::ICR_HLEND_BIT];
    if (!isr_b[hiwp_pkg::ISR_RXDF_BIT]) begin
      rx_load();
      if (!isr_b[hiwp_pkg::ISR_RXDF_BIT]) return 8'h00;
    end
    case (slot)
      hiwp_pkg::SLOT_H: b = little ? rx_cur[7:0] : rx_cur[23:16];
      hiwp_pkg::SLOT_M: b = rx_cur[15:8];
      default: b = little ? rx_cur[23:16] : rx_cur[7:0];
    endcase
    // last byte in the current order frees the receive register
    if ((little && slot == hiwp_pkg::SLOT_H) || (!little && slot == hiwp_pkg::SLOT_L))
      isr_b[hiwp_pkg::ISR_RXDF_BIT] = 1'b0;
    return b;
  endfunction

  function automatic void tx_put(logic [1:0] slot, logic [7:0] v);
    tx_b[slot] = v;
    tx_mask[slot] = 1'b1;
    if (tx_mask != 3'b111) return;
    step_out.tx_valid = 1'b1;
    step_out.tx_word = ctrl_b[hiwp_pkg::ICR_HLEND_BIT]
        ? {tx_b[hiwp_pkg::SLOT_L], tx_b[hiwp_pkg::SLOT_M], tx_b[hiwp_pkg::SLOT_H]}
        : {tx_b[hiwp_pkg::SLOT_H], tx_b[hiwp_pkg::SLOT_M], tx_b[hiwp_pkg::SLOT_L]};
    foreach (tx_b[k]) tx_b[k] = '0;
    tx_mask = '0;
  endfunction

  function automatic logic [7:0] byte_read(logic [2:0] idx);
    case (idx)
      hiwp_pkg::REG_ICR: return ctrl_b;
      hiwp_pkg::REG_CVR: return cvr_b;
      hiwp_pkg::REG_ISR: return isr_b;
      hiwp_pkg::REG_IVR: return ivr_b;
      hiwp_pkg::REG_SPARE: return spare_b;
      hiwp_pkg::REG_TXH: return rx_byte(hiwp_pkg::SLOT_H);
      hiwp_pkg::REG_TXM: return rx_byte(hiwp_pkg::SLOT_M);
      default: return rx_byte(hiwp_pkg::SLOT_L);
    endcase
  endfunction

  function automatic void byte_write(logic [2:0] idx, logic [7:0] v);
    case (idx)
      hiwp_pkg::REG_ICR: ctrl_b = v;
      hiwp_pkg::REG_CVR: begin
        cvr_b = v;
        if (v[hiwp_pkg::CVR_HC_BIT]) begin
          step_out.irq_valid = 1'b1;
          step_out.irq_vector = {v[6:0], 1'b0};
          cvr_b[hiwp_pkg::CVR_HC_BIT] = 1'b0;
        end
      end
      hiwp_pkg::REG_ISR: isr_b = v;
      hiwp_pkg::REG_IVR: ivr_b = v;
      hiwp_pkg::REG_SPARE: spare_b = v;
      hiwp_pkg::REG_TXH: tx_put(hiwp_pkg::SLOT_H, v);
      hiwp_pkg::REG_TXM: tx_put(hiwp_pkg::SLOT_M, v);
      default: tx_put(hiwp_pkg::SLOT_L, v);
    endcase
  endfunction

  function automatic hiwp_pkg::result_t host_port_step(hiwp_pkg::item_t it);
    logic [15:0] rd;
    rd = '0;
    step_out = '0;
    case (it.func)
      hiwp_pkg::FUNC_READ: begin
        if (!it.halfword) begin
          rd[7:0] = byte_read(it.reg_index);
        end else if (it.reg_index == hiwp_pkg::REG_SPARE) begin
          rd[7:0] = rx_byte(hiwp_pkg::SLOT_H);
        end else if (it.reg_index == hiwp_pkg::REG_TXM) begin
          rd[15:8] = rx_byte(hiwp_pkg::SLOT_M);
          rd[7:0] = rx_byte(hiwp_pkg::SLOT_L);
        end
      end
      hiwp_pkg::FUNC_WRITE: begin
        if (!it.halfword) begin
          byte_write(it.reg_index, it.write_data[7:0]);
        end else if (it.reg_index == hiwp_pkg::REG_SPARE) begin
          spare_b = it.write_data[15:8];
          byte_write(hiwp_pkg::REG_TXH, it.write_data[7:0]);
        end else if (it.reg_index == hiwp_pkg::REG_TXM) begin
          byte_write(hiwp_pkg::REG_TXM, it.write_data[15:8]);
          byte_write(hiwp_pkg::REG_TXL, it.write_data[7:0]);
        end
      end
      hiwp_pkg::FUNC_RX_WORD: begin
        if (fifo_cnt >= hiwp_pkg::RX_FIFO_DEPTH) begin
          step_out.rx_overflow = 1'b1;
        end else begin
          rx_fifo[(fifo_head + fifo_cnt) % hiwp_pkg::RX_FIFO_DEPTH] = it.rx_word;
          fifo_cnt++;
        end
        if (!isr_b[hiwp_pkg::ISR_RXDF_BIT]) rx_load();
      end
      default: begin
        // timeout only runs while a word is held and more are waiting
        if (isr_b[hiwp_pkg::ISR_RXDF_BIT] && fifo_cnt != 0) begin
          tmo_cnt = tmo_cnt + int'(it.tick_cycles);
          if (tmo_cnt > 65535) tmo_cnt = 65535;
          if (tmo_cnt >= int'(rx_tmo_limit)) begin
            isr_b[hiwp_pkg::ISR_RXDF_BIT] = 1'b0;
            rx_load();
          end
        end
      end
    endcase
    step_out.read_data = rd;
    step_out.rx_can_accept = !isr_b[hiwp_pkg::ISR_RXDF_BIT];
    return step_out;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got,
                                want));
  endtask

  // sender: bursts of transfers with random gaps
  always @(negedge clk) begin : drive_proc
    hiwp_pkg::item_t nxt;
    logic            nv;
    if (!rst && !(in_valid && accepted != offered)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (bus_items.size() > 0) begin
        nxt = bus_items[0];
        bus_items.delete(0);
        nv = 1'b1;
        func <= nxt.func;
        reg_index <= nxt.reg_index;
        halfword <= nxt.halfword;
        write_data <= nxt.write_data;
        rx_word <= nxt.rx_word;
        tick_cycles <= nxt.tick_cycles;
        offered++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: stall pattern switched at random among four modes, plus one long hold-off
  always @(negedge clk) begin : recv_proc
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && accepted >= 200) begin
      hold_done = 1'b1;
      hold_left = 80;
      rdy = 1'b0;
    end else begin
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = (rcv_cycle % 4) != 3;
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    rcv_cycle++;
    if (rcv_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
    out_ready <= rdy;
  end

  always @(posedge clk) begin : watch_proc
    hiwp_pkg::item_t   it;
    hiwp_pkg::result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (host_port_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = host_port_results[0];
          host_port_results.delete(0);
          check_field("read_data", 32'(read_data), 32'(want.read_data));
          check_field("tx_valid", 32'(tx_valid), 32'(want.tx_valid));
          check_field("tx_word", 32'(tx_word), 32'(want.tx_word));
          check_field("irq_valid", 32'(irq_valid), 32'(want.irq_valid));
          check_field("irq_vector", 32'(irq_vector), 32'(want.irq_vector));
          check_field("rx_can_accept", 32'(rx_can_accept), 32'(want.rx_can_accept));
          check_field("rx_overflow", 32'(rx_overflow), 32'(want.rx_overflow));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        it.func = func;
        it.reg_index = reg_index;
        it.halfword = halfword;
        it.write_data = write_data;
        it.rx_word = rx_word;
        it.tick_cycles = tick_cycles;
        want = host_port_step(it);
        host_port_results.insert(host_port_results.size(), want);
        accepted++;
        tx_words += int'(want.tx_valid);
        vectors += int'(want.irq_valid);
        dropped += int'(want.rx_overflow);
      end
    end
  end

  task automatic add_item(logic [1:0] f, logic [2:0] idx, logic hw, logic [31:0] val);
    hiwp_pkg::item_t it;
    it.func = f;
    it.reg_index = idx;
    it.halfword = hw;
    it.write_data = 16'($urandom);
    it.rx_word = 24'($urandom);
    it.tick_cycles = 16'($urandom);
    case (f)
      hiwp_pkg::FUNC_WRITE: it.write_data = val[15:0];
      hiwp_pkg::FUNC_RX_WORD: it.rx_word = val[23:0];
      hiwp_pkg::FUNC_TICK: it.tick_cycles = val[15:0];
      default: ;
    endcase
    bus_items.insert(bus_items.size(), it);
  endtask

  task automatic add_random_seq();
    int         pick, n, s;
    bit         rev;
    logic [2:0] idx;
    logic [15:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // one transmit word, sometimes after an endian change
      if ($urandom_range(0, 3) == 0)
        add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_ICR, 1'b0, $urandom);
      case ($urandom_range(0, 3))
        0: begin
          s = $urandom_range(0, 2);
          rev = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 5) == 0)
            add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXH + 3'(s), 1'b0, $urandom);
          for (int k = 0; k < 3; k++)
            add_item(hiwp_pkg::FUNC_WRITE,
                     hiwp_pkg::REG_TXH + 3'((s + (rev ? 3 - k : k)) % 3), 1'b0, $urandom);
        end
        1: begin
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_SPARE, 1'b1, $urandom);
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXM, 1'b0, $urandom);
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXL, 1'b0, $urandom);
        end
        2: begin
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXH, 1'b0, $urandom);
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXM, 1'b1, $urandom);
        end
        default: begin
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_SPARE, 1'b1, $urandom);
          add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXM, 1'b1, $urandom);
        end
      endcase
    end else if (pick < 50) begin
      // receive words followed by a read-out of the held word
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++)
        add_item(hiwp_pkg::FUNC_RX_WORD, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 $urandom);
      if ($urandom_range(0, 3) == 0)
        add_item(hiwp_pkg::FUNC_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 40));
      case ($urandom_range(0, 3))
        0: begin
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXH, 1'b0, 0);
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXM, 1'b0, 0);
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXL, 1'b0, 0);
        end
        1: begin
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXL, 1'b0, 0);
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXM, 1'b0, 0);
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXH, 1'b0, 0);
        end
        2: begin
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXM, 1'b1, 0);
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXH, 1'b0, 0);
        end
        default: begin
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_SPARE, 1'b1, 0);
          add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXM, 1'b1, 0);
        end
      endcase
    end else if (pick < 65) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++)
        add_item(hiwp_pkg::FUNC_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40));
    end else if (pick < 75) begin
      v = 16'($urandom);
      if ($urandom_range(0, 3) != 0) v[hiwp_pkg::CVR_HC_BIT] = 1'b1;
      add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_CVR, 1'b0, 32'(v));
      add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_CVR, 1'b0, 0);
    end else if (pick < 85) begin
      idx = 3'($urandom_range(hiwp_pkg::REG_ICR, hiwp_pkg::REG_SPARE));
      add_item(hiwp_pkg::FUNC_WRITE, idx, 1'b0, $urandom);
      add_item(hiwp_pkg::FUNC_READ, idx, 1'b0, 0);
    end else begin
      add_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
               $urandom);
    end
  endtask

  task automatic fill_random_phase(int n);
    // overrun the receive queue once, then drain it by byte reads
    for (int k = 0; k < 20; k++)
      add_item(hiwp_pkg::FUNC_RX_WORD, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
               $urandom);
    for (int k = 0; k < 60; k++)
      add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXH + 3'(k % 3), 1'b0, 0);
    while (bus_items.size() < n) add_random_seq();
  endtask

  task automatic wait_port_idle();
    do @(negedge clk);
    while (bus_items.size() != 0 || in_valid || host_port_results.size() != 0);
  endtask

  task automatic write_timeout(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    rx_tmo_limit = v;
    limits_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main_proc
    logic [7:0] limits [4];
    limits[0] = 8'd1;
    limits[1] = 8'd255;
    limits[2] = 8'($urandom_range(2, 254));
    limits[3] = hiwp_pkg::RX_TIMEOUT_RESET;
    host_port_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_ICR, 1'b0, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_CVR, 1'b0, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_ISR, 1'b0, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_IVR, 1'b0, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_SPARE, 1'b0, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXH, 1'b0, 0);  // nothing queued, reads zero
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXH, 1'b0, 32'h0000FFFF);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXH, 1'b0, 32'h00000A5A);  // same byte again
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXM, 1'b0, 32'h00000000);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXL, 1'b0, 32'h0000FF00);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_ICR, 1'b0, 32'h0000FF20);  // little endian
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_SPARE, 1'b1, 32'h0000ABCD);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_TXM, 1'b1, 32'h00001234);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_CVR, 1'b0, 32'h000000FF);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_CVR, 1'b0, 32'h0000FF80);
    add_item(hiwp_pkg::FUNC_RX_WORD, hiwp_pkg::REG_ICR, 1'b0, 32'h00FFFFFF);
    add_item(hiwp_pkg::FUNC_RX_WORD, hiwp_pkg::REG_TXL, 1'b1, 32'h00000000);
    add_item(hiwp_pkg::FUNC_RX_WORD, hiwp_pkg::REG_ICR, 1'b0, 32'h00A5C3E1);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_TXM, 1'b1, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_SPARE, 1'b1, 0);
    add_item(hiwp_pkg::FUNC_READ, hiwp_pkg::REG_ISR, 1'b1, 0);  // halfword, unsupported index
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_IVR, 1'b1, 32'h0000FFFF);
    add_item(hiwp_pkg::FUNC_TICK, hiwp_pkg::REG_ICR, 1'b0, 32'h0000FFFF);
    add_item(hiwp_pkg::FUNC_TICK, hiwp_pkg::REG_ICR, 1'b0, 32'h00000000);
    add_item(hiwp_pkg::FUNC_WRITE, hiwp_pkg::REG_ISR, 1'b0, 32'h0000FFFF);
    wait_port_idle();

    for (int p = 0; p < 4; p++) begin
      write_timeout(limits[p]);
      @(posedge clk);
      fill_random_phase(230);
      wait_port_idle();
    end

    repeat (10) @(posedge clk);
    if (host_port_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", host_port_results.size()));
    $display("run covered %0d transfers over %0d timeout limits: %0d transmit words,",
             accepted, limits_used, tx_words);
    $display("  %0d host vectors, %0d dropped receive words, %0d mismatches",
             vectors, dropped, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #2000000;
    $display("timeout after %0d of %0d results", results_seen, accepted);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
